// File: hw/rtl/bprr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types, command and status structs and helpers of the unit.
package bprr_pkg;

  localparam int unsigned MaxLen   = 32;
  localparam int unsigned Symbols  = 32;
  localparam int unsigned TblW     = MaxLen + 2;
  localparam int unsigned TblRows  = MaxLen + 1;
  localparam int unsigned TblDepth = TblW * TblRows;
  localparam int unsigned AddrW    = $clog2(TblDepth);
  localparam int unsigned CntW     = 33;
  localparam int unsigned RemW     = $clog2(Symbols + 1);
  localparam int unsigned HW       = $clog2(Symbols + 3);
  localparam int unsigned PosW     = $clog2(Symbols);

  localparam logic OpRank   = 1'b0;
  localparam logic OpUnrank = 1'b1;

  typedef enum logic [1:0] {
    SymEmpty = 2'd0,
    SymUp    = 2'd1,
    SymDown  = 2'd2,
    SymBad   = 2'd3
  } sym_e;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrSymbol = 2'd1,
    ErrEnd    = 2'd2,
    ErrRange  = 2'd3
  } err_e;

  typedef struct packed {
    logic        operation;
    logic [63:0] word_in;
    logic [5:0]  path_length;
    logic [31:0] index_in;
  } bprr_req_t;

  typedef struct packed {
    logic [31:0] index_out;
    logic [63:0] word_out;
    logic [1:0]  error_code;
  } bprr_rsp_t;

  typedef struct packed {
    logic fill;
    logic load;
    logic rank_step;
    logic rank_drain;
    logic rank_fin;
    logic unr_check;
    logic unr_test;
    logic unr_step;
  } bprr_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic scan_last;
    logic range_bad;
    logic step_last;
  } bprr_sts_t;

  // Flat address of the count table entry for a remaining length and a height.
  function automatic logic [AddrW-1:0] tbl_addr(input logic [RemW-1:0] rem,
                                                input logic [HW-1:0] h);
    return AddrW'(AddrW'(rem) * AddrW'(TblW) + AddrW'(h));
  endfunction

  // Number of occupied symbols in a packed word, summed in groups of four.
  function automatic logic [RemW-1:0] count_occupied(input logic [63:0] word);
    logic [RemW-1:0] total;
    logic [2:0]      grp;
    total = '0;
    for (int g = 0; g < Symbols / 4; g++) begin
      grp = 3'd0;
      for (int k = 0; k < 4; k++) begin
        grp = grp + 3'(word[8 * g + 2 * k +: 2] != 2'b00);
      end
      total = total + RemW'(grp);
    end
    return total;
  endfunction

endpackage

// File: hw/rtl/bprr_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
module bprr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hw/rtl/bprr_datapath.sv
`timescale 1ns / 1ps
// Datapath: count table fill, rank scan and unrank steps around the count table RAM.
module bprr_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bprr_pkg::bprr_req_t req_i,
  input  bprr_pkg::bprr_cmd_t cmd_i,
  output bprr_pkg::bprr_sts_t sts_o,
  output bprr_pkg::bprr_rsp_t rsp_o
);
  import bprr_pkg::*;

  typedef enum logic [1:0] {
    FmZero = 2'd0,
    FmOne  = 2'd1,
    FmB    = 2'd2,
    FmSum  = 2'd3
  } fill_mode_e;

  // Table fill state.
  logic [RemW-1:0]  fill_rem_q, fill_rem_d;
  logic [HW-1:0]    fill_h_q, fill_h_d;
  logic             fill_issued_q, fill_issued_d;
  logic             fill_done_q, fill_done_d;
  logic             wr_valid_q, wr_valid_d;
  logic             wr_last_q, wr_last_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  fill_mode_e       wr_mode_q, wr_mode_d;

  // Operation state.
  logic            mode_q, mode_d;
  logic [63:0]     word_q, word_d;
  logic [CntW-1:0] r_q, r_d;
  logic [HW-1:0]   h_q, h_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [RemW-1:0] occ_q, occ_d;
  logic [5:0]      len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            pend_q, pend_d;
  logic            sel_down_q, sel_down_d;
  err_e            err_q, err_d;

  logic [AddrW-1:0] raddr_a, raddr_b;
  logic [CntW-1:0]  rdata_a, rdata_b;
  logic [CntW-1:0]  wdata;
  logic [CntW-1:0]  rc;
  logic [RemW-1:0]  rem_dec;
  logic [RemW-1:0]  occ_new;
  logic             fill_row_ok, fill_col_ok, fill_last;
  logic             len_ok, range_bad, take_down;
  sym_e             sym;

  bprr_ram #(
    .Width(CntW),
    .Depth(TblDepth)
  ) u_tbl (
    .clk_i    (clk_i),
    .we_i     (wr_valid_q),
    .waddr_i  (wr_addr_q),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  always_comb begin
    case (wr_mode_q)
      FmOne:   wdata = CntW'(1);
      FmB:     wdata = rdata_b;
      FmSum:   wdata = rdata_a + rdata_b;
      default: wdata = '0;
    endcase
  end

  always_comb begin
    sym         = sym_e'(word_q[1:0]);
    rem_dec     = rem_q - RemW'(1);
    occ_new     = count_occupied(req_i.word_in);
    fill_row_ok = (fill_rem_q != '0);
    fill_col_ok = (fill_h_q != HW'(TblW - 1));
    fill_last   = (fill_rem_q == RemW'(MaxLen)) && (fill_h_q == HW'(TblW - 1));
    len_ok      = (len_q <= 6'(MaxLen));
    range_bad   = !len_ok || (r_q >= rdata_a);
    rc          = (h_q != '0) ? (sel_down_q ? rdata_a : rdata_b) : '0;
    take_down   = (r_q < rc);

    fill_rem_d    = fill_rem_q;
    fill_h_d      = fill_h_q;
    fill_issued_d = fill_issued_q;
    fill_done_d   = fill_done_q | (wr_valid_q & wr_last_q);
    wr_valid_d    = 1'b0;
    wr_last_d     = wr_last_q;
    wr_addr_d     = wr_addr_q;
    wr_mode_d     = wr_mode_q;

    mode_d     = mode_q;
    word_d     = word_q;
    r_d        = r_q;
    h_d        = h_q;
    rem_d      = rem_q;
    occ_d      = occ_q;
    len_d      = len_q;
    pos_d      = pos_q;
    pend_d     = pend_q;
    sel_down_d = sel_down_q;
    err_d      = err_q;
    raddr_a    = '0;
    raddr_b    = '0;

    // Each row is built from the one below it, one entry per cycle.
    if (cmd_i.fill && !fill_issued_q) begin
      if (fill_row_ok && fill_col_ok) begin
        if (fill_h_q != '0) begin
          raddr_a = tbl_addr(RemW'(fill_rem_q - RemW'(1)), HW'(fill_h_q - HW'(1)));
        end
        raddr_b = tbl_addr(RemW'(fill_rem_q - RemW'(1)), HW'(fill_h_q + HW'(1)));
      end
      wr_valid_d = 1'b1;
      wr_addr_d  = tbl_addr(fill_rem_q, fill_h_q);
      wr_last_d  = fill_last;
      if (!fill_row_ok) begin
        wr_mode_d = (fill_h_q == '0) ? FmOne : FmZero;
      end else if (!fill_col_ok) begin
        wr_mode_d = FmZero;
      end else if (fill_h_q == '0) begin
        wr_mode_d = FmB;
      end else begin
        wr_mode_d = FmSum;
      end
      if (fill_last) begin
        fill_issued_d = 1'b1;
      end else if (!fill_col_ok) begin
        fill_h_d   = '0;
        fill_rem_d = fill_rem_q + RemW'(1);
      end else begin
        fill_h_d = fill_h_q + HW'(1);
      end
    end

    if (cmd_i.load) begin
      mode_d = req_i.operation;
      err_d  = ErrNone;
      pend_d = 1'b0;
      pos_d  = '0;
      h_d    = HW'(1);
      len_d  = req_i.path_length;
      if (req_i.operation == OpRank) begin
        word_d = req_i.word_in;
        r_d    = '0;
        occ_d  = occ_new;
        rem_d  = occ_new;
        if (occ_new > RemW'(MaxLen)) begin
          err_d = ErrSymbol;
        end
      end else begin
        word_d = '0;
        r_d    = CntW'(req_i.index_in);
        rem_d  = RemW'(req_i.path_length) - RemW'(1);
      end
    end

    // The count looked up for an up-step arrives in the following cycle.
    if ((cmd_i.rank_step || cmd_i.rank_drain) && pend_q) begin
      r_d = r_q + rdata_a;
    end

    if (cmd_i.rank_step) begin
      word_d = {2'b00, word_q[63:2]};
      pos_d  = pos_q + PosW'(1);
      pend_d = 1'b0;
      if (err_q == ErrNone) begin
        case (sym)
          SymEmpty: pend_d = 1'b0;
          SymUp: begin
            rem_d = rem_dec;
            h_d   = h_q + HW'(1);
            if (h_q != '0) begin
              raddr_a = tbl_addr(rem_dec, HW'(h_q - HW'(1)));
              pend_d  = 1'b1;
            end
          end
          SymDown: begin
            if (h_q != '0) begin
              h_d   = h_q - HW'(1);
              rem_d = rem_dec;
            end else begin
              err_d = ErrSymbol;
            end
          end
          default: err_d = ErrSymbol;
        endcase
      end
    end

    if (cmd_i.rank_drain) begin
      pend_d = 1'b0;
      if (occ_q <= RemW'(MaxLen)) begin
        raddr_a = tbl_addr(occ_q, HW'(1));
      end
    end

    if (cmd_i.rank_fin && (err_q == ErrNone)) begin
      if (h_q != '0) begin
        err_d = ErrEnd;
      end else if (r_q >= rdata_a) begin
        err_d = ErrRange;
      end
    end

    if (cmd_i.unr_check && len_ok) begin
      raddr_a = tbl_addr(RemW'(len_q), HW'(1));
    end

    if (cmd_i.unr_test) begin
      sel_down_d = 1'b0;
      if (range_bad) begin
        err_d = ErrRange;
      end
      if (len_ok && (len_q != '0)) begin
        raddr_b = tbl_addr(rem_q, '0);
      end
    end

    // Both possible next lookups are fetched while this step decides.
    if (cmd_i.unr_step) begin
      if (take_down) begin
        word_d[{pos_q, 1'b0} +: 2] = SymDown;
        h_d = h_q - HW'(1);
      end else begin
        word_d[{pos_q, 1'b0} +: 2] = SymUp;
        r_d = r_q - rc;
        h_d = h_q + HW'(1);
      end
      sel_down_d = take_down;
      pos_d      = pos_q + PosW'(1);
      rem_d      = rem_dec;
      if (rem_q != '0) begin
        if (h_q >= HW'(2)) begin
          raddr_a = tbl_addr(rem_dec, HW'(h_q - HW'(2)));
        end
        raddr_b = tbl_addr(rem_dec, h_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_rem_q    <= '0;
      fill_h_q      <= '0;
      fill_issued_q <= 1'b0;
      fill_done_q   <= 1'b0;
      wr_valid_q    <= 1'b0;
      pend_q        <= 1'b0;
      err_q         <= ErrNone;
    end else begin
      fill_rem_q    <= fill_rem_d;
      fill_h_q      <= fill_h_d;
      fill_issued_q <= fill_issued_d;
      fill_done_q   <= fill_done_d;
      wr_valid_q    <= wr_valid_d;
      pend_q        <= pend_d;
      err_q         <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_last_q  <= wr_last_d;
    wr_addr_q  <= wr_addr_d;
    wr_mode_q  <= wr_mode_d;
    mode_q     <= mode_d;
    word_q     <= word_d;
    r_q        <= r_d;
    h_q        <= h_d;
    rem_q      <= rem_d;
    occ_q      <= occ_d;
    len_q      <= len_d;
    pos_q      <= pos_d;
    sel_down_q <= sel_down_d;
  end

  assign sts_o.fill_done = fill_done_q;
  assign sts_o.scan_last = (pos_q == PosW'(Symbols - 1));
  assign sts_o.range_bad = range_bad;
  assign sts_o.step_last = (rem_q == '0);

  assign rsp_o.index_out  = ((mode_q == OpRank) && (err_q == ErrNone)) ? r_q[31:0] : '0;
  assign rsp_o.word_out   = ((mode_q != OpRank) && (err_q == ErrNone)) ? word_q : '0;
  assign rsp_o.error_code = err_q;

endmodule

// File: hw/rtl/bprr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences the table fill, the rank scan and the unrank steps.
module bprr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                op_i,
  input  bprr_pkg::bprr_sts_t sts_i,
  output bprr_pkg::bprr_cmd_t cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import bprr_pkg::*;

  typedef enum logic [8:0] {
    StFill      = 9'b000000001,
    StIdle      = 9'b000000010,
    StRankScan  = 9'b000000100,
    StRankDrain = 9'b000001000,
    StRankFin   = 9'b000010000,
    StUnrCheck  = 9'b000100000,
    StUnrTest   = 9'b001000000,
    StUnrStep   = 9'b010000000,
    StDone      = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   busy;
  logic   accept;

  assign busy   = !((state_q == StIdle) || (state_q == StDone));
  assign accept = start_i && !busy;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.load = accept;
    case (state_q)
      StFill: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_done) begin
          state_d = StIdle;
        end
      end
      StIdle, StDone: begin
        state_d = StIdle;
        if (accept) begin
          state_d = (op_i == OpUnrank) ? StUnrCheck : StRankScan;
        end
      end
      StRankScan: begin
        cmd_o.rank_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StRankDrain;
        end
      end
      StRankDrain: begin
        cmd_o.rank_drain = 1'b1;
        state_d = StRankFin;
      end
      StRankFin: begin
        cmd_o.rank_fin = 1'b1;
        state_d = StDone;
      end
      StUnrCheck: begin
        cmd_o.unr_check = 1'b1;
        state_d = StUnrTest;
      end
      StUnrTest: begin
        cmd_o.unr_test = 1'b1;
        state_d = sts_i.range_bad ? StDone : StUnrStep;
      end
      StUnrStep: begin
        cmd_o.unr_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = StDone;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StFill;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = busy;
  assign done_o = (state_q == StDone);

endmodule

// File: hw/rtl/ballot_path_rank_unrank_unit.sv
`timescale 1ns / 1ps
// Top level of the ballot path rank and unrank unit.
//
// A request is taken at a rising edge with start high and busy low. In rank mode
// the packed word is scanned one position per cycle over all 32 positions, empty
// ones included, with one table lookup per up-step above height zero. In unrank mode
// one symbol is decided per cycle, both possible next lookups being fetched from
// the two read ports of the count table while the current step decides.
// The result stays on rsp_o until the next request is taken; done_o marks it for
// a single cycle, taken at the edge that ends it; the receiver cannot hold it off.
// Rank: the scan is followed by a drain state and a finish state before done_o,
// and a new request may be taken in the done_o cycle, but not before it.
// Unrank: a check state and a test state come before the steps, one per symbol of
// the path, or the test goes straight to done_o for an index or length out of range.
// After reset the count table is built row by row, one entry per cycle, from the
// row below it; busy stays high while this runs.
module ballot_path_rank_unrank_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bprr_pkg::bprr_req_t req_i,
  output logic                done_o,
  output bprr_pkg::bprr_rsp_t rsp_o
);
  import bprr_pkg::*;

  bprr_cmd_t cmd;
  bprr_sts_t sts;

  bprr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (req_i.operation),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  bprr_datapath u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

endmodule
